@@ hdl/ijm_pkg.sv @@
`default_nettype none

package ijm_pkg;

   // Field widths
   localparam int STAT_W   = 64;             // counts, totals, intervals
   localparam int TS_W     = 64;             // timestamp field as carried on the channel
   localparam int CFG_W    = 32;             // interval register
   localparam int JIT_W    = 32;             // jitter percent
   localparam int PCT_W    = STAT_W + 7;     // excess * 100 fits here

   // Serial divider sequencing
   localparam int DIV_STEPS = PCT_W;         // one quotient bit per cycle
   localparam int AVG_STEPS = STAT_W;        // average runs in the last 64 of them
   localparam int CNT_W     = 7;

   // Report every tenth beat
   localparam int          MOD_W       = 4;
   localparam logic [MOD_W-1:0] REPORT_LAST = 4'd9;

   localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd2400000;

   // Command codes
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
   } ijm_div_ctl_type;

endpackage

`default_nettype wire

@@ hdl/ijm_req_if.sv @@
`default_nettype none

interface ijm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ijm_pkg::TS_W-1:0]    timestamp;

   modport source (output valid, output cmd, output timestamp, input ready);
   modport sink   (input valid, input cmd, input timestamp, output ready);
endinterface

`default_nettype wire

@@ hdl/ijm_rsp_if.sv @@
`default_nettype none

interface ijm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         beat;
   logic [ijm_pkg::STAT_W-1:0]   beat_number;
   logic [ijm_pkg::STAT_W-1:0]   interval;
   logic [ijm_pkg::JIT_W-1:0]    jitter;
   logic [ijm_pkg::STAT_W-1:0]   least_interval;
   logic [ijm_pkg::STAT_W-1:0]   greatest_interval;
   logic [ijm_pkg::JIT_W-1:0]    peak_jitter;
   logic [ijm_pkg::STAT_W-1:0]   average_interval;
   logic                         report_due;

   modport source (output valid, output beat, output beat_number, output interval,
                   output jitter, output least_interval, output greatest_interval,
                   output peak_jitter, output average_interval, output report_due,
                   input ready);
   modport sink   (input valid, input beat, input beat_number, input interval,
                   input jitter, input least_interval, input greatest_interval,
                   input peak_jitter, input average_interval, input report_due,
                   output ready);
endinterface

`default_nettype wire

@@ hdl/ijm_sdiv.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle while ctl.step is high. The dividend shifts out
// MSB first, the quotient shifts in LSB last; NUM_W steps give the result.
module ijm_sdiv #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 64
) (
   input  logic                     clock,
   input  ijm_pkg::ijm_div_ctl_type ctl,
   input  logic [NUM_W-1:0]         dividend,
   input  logic [DEN_W-1:0]         divisor,
   output logic [NUM_W-1:0]         quotient
);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff,   q_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;
   logic             ge;

   // one trial subtraction
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - (DEN_W+2)'(den_ff);
      ge     = !diff[DEN_W+1];

      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      if (ctl.load) begin
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
         q_in   = '0;
      end else if (ctl.step) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;

endmodule

`default_nettype wire

@@ hdl/interval_jitter_monitor.sv @@
`default_nettype none

// A sample without a beat, or a restart, goes from accept through evaluate to the output register.
// A beat goes through evaluate, load, the bit-serial dividers
// (jitter and average run side by side), finish, output.
// One item at a time: a new item is taken only once the last is handed to the output register;
// the next item is taken while a result waits.
// Reset (synchronous): interval 2400000, statistics cleared, reference time 0.
module interval_jitter_monitor #(
   parameter int TIMESTAMP_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   ijm_req_if.sink                  req_chan,
   ijm_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [ijm_pkg::CFG_W-1:0] csr_wdata
);
   import ijm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // control
   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]        interval_ff, interval_in;

   // statistics
   logic [TIMESTAMP_BITS-1:0] ref_ff, ref_in;
   logic [STAT_W-1:0]       total_ff, total_in;
   logic [STAT_W-1:0]       sum_ff, sum_in;
   logic [STAT_W-1:0]       min_ff, min_in;
   logic [STAT_W-1:0]       max_ff, max_in;
   logic [JIT_W-1:0]        peak_ff, peak_in;
   logic [STAT_W-1:0]       avg_ff, avg_in;
   logic [MOD_W-1:0]        mod_ff, mod_in;

   // item in flight
   logic                    cmd_ff, cmd_in;
   logic [TIMESTAMP_BITS-1:0] now_ff, now_in;
   logic [STAT_W-1:0]       excess_ff, excess_in;
   logic                    res_beat_ff, res_beat_in;
   logic [STAT_W-1:0]       res_interval_ff, res_interval_in;
   logic [JIT_W-1:0]        res_jitter_ff, res_jitter_in;
   logic                    res_report_ff, res_report_in;

   // output register
   logic                    out_beat_ff, out_beat_in;
   logic [STAT_W-1:0]       out_number_ff, out_number_in;
   logic [STAT_W-1:0]       out_interval_ff, out_interval_in;
   logic [JIT_W-1:0]        out_jitter_ff, out_jitter_in;
   logic [STAT_W-1:0]       out_least_ff, out_least_in;
   logic [STAT_W-1:0]       out_greatest_ff, out_greatest_in;
   logic [JIT_W-1:0]        out_peak_ff, out_peak_in;
   logic [STAT_W-1:0]       out_average_ff, out_average_in;
   logic                    out_report_ff, out_report_in;

   // datapath
   logic [TIMESTAMP_BITS-1:0] elapsed_ts;
   logic [STAT_W-1:0]       elapsed;
   logic [STAT_W:0]         diff;
   logic                    is_beat;
   logic [STAT_W-1:0]       total_inc;
   logic [MOD_W-1:0]        mod_next;
   logic [PCT_W-1:0]        excess_w;
   logic [PCT_W-1:0]        pct;
   logic [JIT_W-1:0]        jit_val;

   ijm_div_ctl_type         jit_ctl, avg_ctl;
   logic [PCT_W-1:0]        jit_q;
   logic [STAT_W-1:0]       avg_q;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // jitter: floor(excess * 100 / interval), 71 quotient bits
   ijm_sdiv #(.NUM_W(PCT_W), .DEN_W(CFG_W)) u_jit_div (
      .clock    (clock),
      .ctl      (jit_ctl),
      .dividend (pct),
      .divisor  (interval_ff),
      .quotient (jit_q)
   );

   // average: tick total / beat count
   ijm_sdiv #(.NUM_W(STAT_W), .DEN_W(STAT_W)) u_avg_div (
      .clock    (clock),
      .ctl      (avg_ctl),
      .dividend (sum_ff),
      .divisor  (total_ff),
      .quotient (avg_q)
   );

   // elapsed time, beat test, report count, jitter scaling and divider control
   always_comb begin
      elapsed_ts = now_ff - ref_ff;
      elapsed    = STAT_W'(elapsed_ts);
      diff       = (STAT_W+1)'(elapsed) - (STAT_W+1)'(interval_ff);
      is_beat    = !diff[STAT_W];
      total_inc  = total_ff + STAT_W'(1);
      if (total_inc == '0) begin
         mod_next = '0;
      end else if (mod_ff == REPORT_LAST) begin
         mod_next = '0;
      end else begin
         mod_next = mod_ff + MOD_W'(1);
      end
      // excess * 100 = excess * (64 + 32 + 4)
      excess_w = PCT_W'(excess_ff);
      pct      = (excess_w << 6) + (excess_w << 5) + (excess_w << 2);
      jit_val  = (|jit_q[PCT_W-1:JIT_W]) ? '1 : jit_q[JIT_W-1:0];

      jit_ctl.load = (state_ff == ST_LOAD);
      jit_ctl.step = (state_ff == ST_DIV);
      avg_ctl.load = (state_ff == ST_LOAD);
      avg_ctl.step = (state_ff == ST_DIV) && (cnt_ff < CNT_W'(AVG_STEPS));
   end

   // sequencer and statistics update
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      interval_in     = csr_we ? csr_wdata : interval_ff;
      ref_in          = ref_ff;
      total_in        = total_ff;
      sum_in          = sum_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      peak_in         = peak_ff;
      avg_in          = avg_ff;
      mod_in          = mod_ff;
      cmd_in          = cmd_ff;
      now_in          = now_ff;
      excess_in       = excess_ff;
      res_beat_in     = res_beat_ff;
      res_interval_in = res_interval_ff;
      res_jitter_in   = res_jitter_ff;
      res_report_in   = res_report_ff;
      out_beat_in     = out_beat_ff;
      out_number_in   = out_number_ff;
      out_interval_in = out_interval_ff;
      out_jitter_in   = out_jitter_ff;
      out_least_in    = out_least_ff;
      out_greatest_in = out_greatest_ff;
      out_peak_in     = out_peak_ff;
      out_average_in  = out_average_ff;
      out_report_in   = out_report_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               now_in   = req_chan.timestamp[TIMESTAMP_BITS-1:0];
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_jitter_in = '0;
            res_report_in = 1'b0;
            res_beat_in   = 1'b0;
            if (cmd_ff == CMD_RESTART) begin
               ref_in          = now_ff;
               total_in        = '0;
               sum_in          = '0;
               min_in          = '1;
               max_in          = '0;
               peak_in         = '0;
               avg_in          = '0;
               mod_in          = '0;
               res_interval_in = '0;
               state_in        = ST_DONE;
            end else if (is_beat) begin
               ref_in          = now_ff;
               total_in        = total_inc;
               sum_in          = sum_ff + elapsed;
               mod_in          = mod_next;
               if (elapsed < min_ff) begin
                  min_in = elapsed;
               end
               if (elapsed > max_ff) begin
                  max_in = elapsed;
               end
               excess_in       = diff[STAT_W-1:0];
               res_beat_in     = 1'b1;
               res_interval_in = elapsed;
               res_report_in   = (mod_next == '0);
               state_in        = ST_LOAD;
            end else begin
               res_interval_in = elapsed;
               state_in        = ST_DONE;
            end
         end
         ST_LOAD: begin
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_jitter_in = jit_val;
            if (jit_val > peak_ff) begin
               peak_in = jit_val;
            end
            avg_in   = (total_ff == '0) ? '0 : avg_q;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               out_beat_in     = res_beat_ff;
               out_number_in   = total_ff;
               out_interval_in = res_interval_ff;
               out_jitter_in   = res_jitter_ff;
               out_least_in    = min_ff;
               out_greatest_in = max_ff;
               out_peak_in     = peak_ff;
               out_average_in  = avg_ff;
               out_report_in   = res_report_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         ref_ff       <= '0;
         total_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         peak_ff      <= '0;
         avg_ff       <= '0;
         mod_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
         ref_ff       <= ref_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         peak_ff      <= peak_in;
         avg_ff       <= avg_in;
         mod_ff       <= mod_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      now_ff          <= now_in;
      excess_ff       <= excess_in;
      res_beat_ff     <= res_beat_in;
      res_interval_ff <= res_interval_in;
      res_jitter_ff   <= res_jitter_in;
      res_report_ff   <= res_report_in;
      out_beat_ff     <= out_beat_in;
      out_number_ff   <= out_number_in;
      out_interval_ff <= out_interval_in;
      out_jitter_ff   <= out_jitter_in;
      out_least_ff    <= out_least_in;
      out_greatest_ff <= out_greatest_in;
      out_peak_ff     <= out_peak_in;
      out_average_ff  <= out_average_in;
      out_report_ff   <= out_report_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.beat              = out_beat_ff;
   assign rsp_chan.beat_number       = out_number_ff;
   assign rsp_chan.interval          = out_interval_ff;
   assign rsp_chan.jitter            = out_jitter_ff;
   assign rsp_chan.least_interval    = out_least_ff;
   assign rsp_chan.greatest_interval = out_greatest_ff;
   assign rsp_chan.peak_jitter       = out_peak_ff;
   assign rsp_chan.average_interval  = out_average_ff;
   assign rsp_chan.report_due        = out_report_ff;

   // accepted item goes straight to evaluation
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == ST_EVAL)
      else $error("accepted item did not enter evaluation");

   // once any beat is counted, least never exceeds greatest
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      total_ff != '0 |-> min_ff <= max_ff)
      else $error("least interval above greatest interval");

   // no beat means no jitter and no report
   a_no_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.beat |-> rsp_chan.jitter == '0 && !rsp_chan.report_due)
      else $error("jitter or report without a beat");

   // peak covers the jitter shown with it
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.peak_jitter >= rsp_chan.jitter)
      else $error("peak jitter below item jitter");

   // divider step count stays in range
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < CNT_W'(DIV_STEPS))
      else $error("divider step count out of range");

endmodule

`default_nettype wire
